[hdl/rqad_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rqad_pkg: shared types and constants of the range anomaly detector
// Widths, per-channel entry layout, forwarding and update records, codes.
// ----------------------------------------------------------------------------
package rqad_pkg;

  localparam int CHANNELS    = 16;
  localparam int SAMPLE_BITS = 32;
  localparam int CH_W        = 4;
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_EXT_W    = (CH_IDX_W > CH_W) ? CH_IDX_W : CH_W;
  localparam int COUNT_W     = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_W      = 16;
  localparam int SPAN_W      = SAMPLE_BITS + 1;
  localparam int PROD_W      = SPAN_W + FRAC_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX             = '1;
  localparam logic [CFG_W-1:0]   WARN_FRACTION_RESET   = 16'd655;
  localparam logic [CFG_W-1:0]   TRAINING_LENGTH_RESET = 16'd10;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CH_IDX_W-1:0]           idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARN_FRACTION   = 2'd0,
    REG_TRAINING_LENGTH = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ANOM_NORMAL = 2'd0,
    ANOM_LOW    = 2'd1,
    ANOM_HIGH   = 2'd2
  } anom_t;

  // One table entry per channel.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    sample_t            rmin;
    sample_t            rmax;
    sample_t            llow;
    sample_t            lhigh;
  } entry_t;

  // An entry that is newer than what the table read returned.
  typedef struct packed {
    logic   hit;
    idx_t   idx;
    entry_t ent;
  } fwd_t;

  // What the update stage hands to the limit stages.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    sample_t            rmin;
    sample_t            rmax;
    sample_t            old_low;
    sample_t            old_high;
    logic [SPAN_W-1:0]  span;
    logic               armed;
    logic               recompute;
    logic               defer;
  } upd_t;

  function automatic logic chan_ok(input logic [CH_W-1:0] ch);
    return (32'(ch) < 32'(CHANNELS));
  endfunction

  function automatic idx_t chan_idx(input logic [CH_W-1:0] ch);
    logic [CH_EXT_W-1:0] ext;
    ext = CH_EXT_W'(ch);
    return ext[CH_IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/range_quantile_anomaly_detector_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// range_quantile_anomaly_detector_core: per-channel min/max range detector
// Keeps count, min, max and limits per channel in a table and judges each
// sample against the limits the channel held before it.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_channel, in_sample
//   out_      output     out_valid/out_stall  out_channel, out_anomaly,
//                                             out_armed, out_low_limit,
//                                             out_high_limit
//   cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// One item is taken every cycle while in_stall is low, also back to back on
// one channel; the single table read and write per item sets that figure.
// An accepted item passes through S1, S2 and S3 into the result register.
// rst_n is synchronous and clears the table through its valid bits at once,
// so items can be taken as soon as reset is released.
// A stalled output holds every stage that is full; empty stages still fill,
// so up to four items can be held while out_stall is high.
//
// Pipeline:
//   S1  table read data arrives; the newest copy of the entry is chosen
//       from the stages ahead, the last write, or the table. Count, min and
//       max are updated and the span is formed.
//   S2  span times warn_fraction. If the item ahead was on the same channel,
//       its freshly computed limits are taken here as the old limits.
//   S3  margin, new limits and judgement; the entry is written back.
//   out result register.
// ----------------------------------------------------------------------------
module range_quantile_anomaly_detector_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [rqad_pkg::CH_W-1:0]         in_channel,
  input  rqad_pkg::sample_t                in_sample,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [rqad_pkg::CH_W-1:0]        out_channel,
  output logic [1:0]                       out_anomaly,
  output logic                             out_armed,
  output rqad_pkg::sample_t                out_low_limit,
  output rqad_pkg::sample_t                out_high_limit,
  input  wire                              cfg_we,
  input  wire [rqad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [rqad_pkg::CFG_W-1:0]        cfg_wdata
);
  import rqad_pkg::*;

  // Configuration.
  logic [CFG_W-1:0] warn_fraction_r;
  logic [CFG_W-1:0] training_length_r;

  // Stage registers.
  logic              s1_vld_r;
  logic [CH_W-1:0]   s1_ch_r;
  sample_t           s1_sample_r;

  logic              s2_vld_r;
  logic              s2_ok_r;
  logic [CH_W-1:0]   s2_ch_r;
  sample_t           s2_sample_r;
  upd_t              s2_upd_r;

  logic              s3_vld_r;
  logic              s3_ok_r;
  logic [CH_W-1:0]   s3_ch_r;
  sample_t           s3_sample_r;
  logic [COUNT_W-1:0] s3_count_r;
  sample_t           s3_rmin_r;
  sample_t           s3_rmax_r;
  logic              s3_armed_r;
  logic              s3_recompute_r;
  sample_t           s3_old_low_r;
  sample_t           s3_old_high_r;
  logic [PROD_W-1:0] s3_prod_r;

  logic              out_vld_r;
  logic [CH_W-1:0]   out_ch_r;
  anom_t             out_anom_r;
  logic              out_armed_r;
  sample_t           out_low_r;
  sample_t           out_high_r;

  fwd_t              wb_r;

  // Stage load enables: a stage takes new contents when it is empty or
  // when its own contents move on.
  logic ld1, ld2, ld3, ld_out;

  logic              s1_ok;
  entry_t            mem_rd;
  fwd_t              s2_fwd;
  fwd_t              s3_fwd;
  upd_t              upd;
  sample_t           lim_low;
  sample_t           lim_high;
  anom_t             s3_anom;
  logic              wr_en;
  entry_t            wr_ent;
  logic [PROD_W-1:0] prod_nxt;

  assign ld_out   = !out_vld_r || !out_stall;
  assign ld3      = !s3_vld_r || ld_out;
  assign ld2      = !s2_vld_r || ld3;
  assign ld1      = !s1_vld_r || ld2;
  assign in_stall = !ld1;

  // --------------------------------------------------------------------------
  // Configuration writes. An index past the list is ignored.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_fraction_r   <= WARN_FRACTION_RESET;
      training_length_r <= TRAINING_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WARN_FRACTION:   warn_fraction_r   <= cfg_wdata;
        REG_TRAINING_LENGTH: training_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Table. The read is issued as the item is accepted and its data lines up
  // with the item in S1; it only advances together with S1.
  // --------------------------------------------------------------------------
  rqad_entry_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ld1),
    .rd_idx  (chan_idx(in_channel)),
    .rd_data (mem_rd),
    .wr_en   (wr_en),
    .wr_idx  (chan_idx(s3_ch_r)),
    .wr_data (wr_ent)
  );

  // --------------------------------------------------------------------------
  // S1: forwarding and update. An item that is held in S1 means everything
  // ahead is stalled, so no write slips past it.
  // --------------------------------------------------------------------------
  assign s1_ok = chan_ok(s1_ch_r);

  always_comb begin
    s2_fwd.hit        = s2_vld_r && s2_ok_r;
    s2_fwd.idx        = chan_idx(s2_ch_r);
    s2_fwd.ent.count  = s2_upd_r.count;
    s2_fwd.ent.rmin   = s2_upd_r.rmin;
    s2_fwd.ent.rmax   = s2_upd_r.rmax;
    s2_fwd.ent.llow   = '0;
    s2_fwd.ent.lhigh  = '0;

    s3_fwd.hit        = s3_vld_r && s3_ok_r;
    s3_fwd.idx        = chan_idx(s3_ch_r);
    s3_fwd.ent        = wr_ent;
  end

  rqad_update u_update (
    .sample          (s1_sample_r),
    .idx             (chan_idx(s1_ch_r)),
    .mem_ent         (mem_rd),
    .s2_fwd          (s2_fwd),
    .s3_fwd          (s3_fwd),
    .wb_fwd          (wb_r),
    .training_length (training_length_r),
    .upd             (upd)
  );

  // --------------------------------------------------------------------------
  // S2: scale the span. The margin is floor(span * fraction / 2^16).
  // --------------------------------------------------------------------------
  assign prod_nxt = PROD_W'(s2_upd_r.span) * PROD_W'(warn_fraction_r);

  // --------------------------------------------------------------------------
  // S3: limits, judgement and write-back.
  // --------------------------------------------------------------------------
  rqad_limit_calc u_limit (
    .prod      (s3_prod_r),
    .rmin      (s3_rmin_r),
    .rmax      (s3_rmax_r),
    .recompute (s3_recompute_r),
    .old_low   (s3_old_low_r),
    .old_high  (s3_old_high_r),
    .sample    (s3_sample_r),
    .armed     (s3_armed_r),
    .new_low   (lim_low),
    .new_high  (lim_high),
    .anomaly   (s3_anom)
  );

  assign wr_ent.count = s3_count_r;
  assign wr_ent.rmin  = s3_rmin_r;
  assign wr_ent.rmax  = s3_rmax_r;
  assign wr_ent.llow  = lim_low;
  assign wr_ent.lhigh = lim_high;
  // A channel past the table leaves every entry alone.
  assign wr_en = s3_vld_r && s3_ok_r && ld_out;

  // --------------------------------------------------------------------------
  // Valid bits and the last-write record.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      wb_r.hit  <= 1'b0;
    end else begin
      if (ld1) begin
        s1_vld_r <= in_valid;
      end
      if (ld2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (ld3) begin
        s3_vld_r <= s2_vld_r;
      end
      if (ld_out) begin
        out_vld_r <= s3_vld_r;
      end
      if (wr_en) begin
        wb_r.hit <= 1'b1;
        wb_r.idx <= chan_idx(s3_ch_r);
        wb_r.ent <= wr_ent;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_ch_r     <= in_channel;
      s1_sample_r <= in_sample;
    end
    if (ld2) begin
      s2_ok_r     <= s1_ok;
      s2_ch_r     <= s1_ch_r;
      s2_sample_r <= s1_sample_r;
      s2_upd_r    <= upd;
    end
    if (ld3) begin
      s3_ok_r        <= s2_ok_r;
      s3_ch_r        <= s2_ch_r;
      s3_sample_r    <= s2_sample_r;
      s3_count_r     <= s2_upd_r.count;
      s3_rmin_r      <= s2_upd_r.rmin;
      s3_rmax_r      <= s2_upd_r.rmax;
      s3_armed_r     <= s2_upd_r.armed;
      s3_recompute_r <= s2_upd_r.recompute;
      // With a deferred entry the item directly ahead, now in S3, is on the
      // same channel and its limits are the ones this item is judged by.
      s3_old_low_r   <= s2_upd_r.defer ? lim_low  : s2_upd_r.old_low;
      s3_old_high_r  <= s2_upd_r.defer ? lim_high : s2_upd_r.old_high;
      s3_prod_r      <= prod_nxt;
    end
    if (ld_out) begin
      out_ch_r    <= s3_ch_r;
      out_anom_r  <= s3_ok_r ? s3_anom : ANOM_NORMAL;
      out_armed_r <= s3_ok_r && s3_armed_r;
      out_low_r   <= s3_ok_r ? lim_low  : '0;
      out_high_r  <= s3_ok_r ? lim_high : '0;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_channel    = out_ch_r;
  assign out_anomaly    = out_anom_r;
  assign out_armed      = out_armed_r;
  assign out_low_limit  = out_low_r;
  assign out_high_limit = out_high_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // A deferred entry relies on the same channel sitting directly ahead.
  a_defer_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_upd_r.defer) |-> (s3_vld_r && s3_ok_r && (s3_ch_r == s2_ch_r)))
    else $error("deferred limits without a matching item in S3");

  // No table write may happen while the result register is held.
  a_no_write_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !wr_en)
    else $error("table written while the output is stalled");

  // Every in-range item has been counted at least once.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_ok_r) |-> (s2_upd_r.count != '0))
    else $error("observation count is zero after an update");

  // A flagged sample only comes from an armed channel.
  a_flag_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((out_anom_r == ANOM_NORMAL) || out_armed_r))
    else $error("anomaly reported on a channel still in training");

endmodule
`default_nettype wire

[hdl/rqad_entry_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rqad_entry_mem: per-channel state table
// One write and one registered read per cycle. Entries never written read
// as zero through a per-entry valid bit that reset clears.
// ----------------------------------------------------------------------------
module rqad_entry_mem (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   rd_en,
  input  rqad_pkg::idx_t        rd_idx,
  output rqad_pkg::entry_t      rd_data,
  input  wire                   wr_en,
  input  rqad_pkg::idx_t        wr_idx,
  input  rqad_pkg::entry_t      wr_data
);
  import rqad_pkg::*;

  entry_t              mem_r [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  entry_t              rd_ent_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_ent_r <= mem_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_idx];
      end
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_ent_r : '0;

endmodule
`default_nettype wire

[hdl/rqad_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rqad_update: forwarding select and count / min / max update
// Picks the newest copy of the channel entry and applies one sample to it.
// ----------------------------------------------------------------------------
module rqad_update (
  input  rqad_pkg::sample_t             sample,
  input  rqad_pkg::idx_t                idx,
  input  rqad_pkg::entry_t              mem_ent,
  input  rqad_pkg::fwd_t                s2_fwd,
  input  rqad_pkg::fwd_t                s3_fwd,
  input  rqad_pkg::fwd_t                wb_fwd,
  input  wire [rqad_pkg::CFG_W-1:0]     training_length,
  output rqad_pkg::upd_t                upd
);
  import rqad_pkg::*;

  always_comb begin
    entry_t             base;
    logic [COUNT_W-1:0] cnt_new;
    sample_t            seed_min;
    sample_t            seed_max;
    logic               lo_move;
    logic               hi_move;

    base      = mem_ent;
    upd.defer = 1'b0;
    // Newest source wins: the item just ahead, then the one in S3, then
    // the last entry written.
    if (wb_fwd.hit && (wb_fwd.idx == idx)) begin
      base = wb_fwd.ent;
    end
    if (s3_fwd.hit && (s3_fwd.idx == idx)) begin
      base = s3_fwd.ent;
    end
    if (s2_fwd.hit && (s2_fwd.idx == idx)) begin
      base.count = s2_fwd.ent.count;
      base.rmin  = s2_fwd.ent.rmin;
      base.rmax  = s2_fwd.ent.rmax;
      // Its limits are not worked out yet; they are picked up one stage on.
      upd.defer  = 1'b1;
    end

    cnt_new   = (base.count == COUNT_MAX) ? base.count : base.count + COUNT_W'(1);
    upd.armed = (cnt_new > training_length);

    if (!upd.armed && (cnt_new == COUNT_W'(1))) begin
      seed_min = sample;
      seed_max = sample;
    end else begin
      seed_min = base.rmin;
      seed_max = base.rmax;
    end

    lo_move = ($signed(sample) < $signed(seed_min));
    hi_move = ($signed(sample) > $signed(seed_max));

    upd.count     = cnt_new;
    upd.rmin      = lo_move ? sample : seed_min;
    upd.rmax      = hi_move ? sample : seed_max;
    upd.old_low   = base.llow;
    upd.old_high  = base.lhigh;
    upd.recompute = upd.armed ? (lo_move || hi_move) : (cnt_new == training_length);
    upd.span      = {upd.rmax[SAMPLE_BITS-1], upd.rmax} - {upd.rmin[SAMPLE_BITS-1], upd.rmin};
  end

endmodule
`default_nettype wire

[hdl/rqad_limit_calc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rqad_limit_calc: limit recompute and sample judgement
// Turns the scaled span into a margin, sets the limits and flags the sample.
// ----------------------------------------------------------------------------
module rqad_limit_calc (
  input  wire [rqad_pkg::PROD_W-1:0] prod,
  input  rqad_pkg::sample_t          rmin,
  input  rqad_pkg::sample_t          rmax,
  input  wire                        recompute,
  input  rqad_pkg::sample_t          old_low,
  input  rqad_pkg::sample_t          old_high,
  input  rqad_pkg::sample_t          sample,
  input  wire                        armed,
  output rqad_pkg::sample_t          new_low,
  output rqad_pkg::sample_t          new_high,
  output rqad_pkg::anom_t            anomaly
);
  import rqad_pkg::*;

  logic [SPAN_W-1:0] delta;

  // The margin is below the span, so both limits stay between min and max.
  assign delta    = prod[PROD_W-1:FRAC_W];
  assign new_low  = recompute ? sample_t'(rmin + delta[SAMPLE_BITS-1:0]) : old_low;
  assign new_high = recompute ? sample_t'(rmax - delta[SAMPLE_BITS-1:0]) : old_high;

  always_comb begin
    anomaly = ANOM_NORMAL;
    if (armed) begin
      if ($signed(sample) < $signed(old_low)) begin
        anomaly = ANOM_LOW;
      end else if ($signed(sample) > $signed(old_high)) begin
        anomaly = ANOM_HIGH;
      end
    end
  end

endmodule
`default_nettype wire
